// ----- hw/rtl/cts_pkg.sv -----
package cts_pkg;

  localparam int AngleW  = 16;
  localparam int MagW    = 16;
  localparam int CosW    = 20;
  localparam int CountW  = 4;
  localparam int X2W     = 31;
  localparam int TermW   = 33;
  localparam int ProdW   = 40;
  localparam int SumW    = 38;
  localparam int RecipW  = 24;
  localparam int HalfW   = 20;
  localparam int PpW     = HalfW + X2W;
  localparam int AccW    = 64;
  localparam int FracW   = 24;
  localparam int RndW    = SumW - 10;

  localparam int MAX_TERMS = 12;
  localparam int TERM_COUNT_RESET = 6;

  localparam logic [1:0] OP_SQ = 2'd0;
  localparam logic [1:0] OP_TX = 2'd1;
  localparam logic [1:0] OP_PR = 2'd2;

  typedef struct packed {
    logic              load_angle;
    logic              mul_lo;
    logic              mul_hi;
    logic [1:0]        op_sel;
    logic              wr_x2;
    logic              wr_p;
    logic              wr_t;
    logic              s_upd;
    logic [CountW-1:0] k;
    logic              out_load;
  } cts_cmd_t;

  typedef struct packed {
    logic out_ready;
  } cts_status_t;

  function automatic logic [RecipW-1:0] recip(input logic [CountW-1:0] idx);
    logic [RecipW-1:0] r;
    case (idx)
      4'd0:    r = 24'd8388608;
      4'd1:    r = 24'd1398101;
      4'd2:    r = 24'd559241;
      4'd3:    r = 24'd299593;
      4'd4:    r = 24'd186414;
      4'd5:    r = 24'd127100;
      4'd6:    r = 24'd92183;
      4'd7:    r = 24'd69905;
      4'd8:    r = 24'd54828;
      4'd9:    r = 24'd44151;
      4'd10:   r = 24'd36314;
      4'd11:   r = 24'd30394;
      4'd12:   r = 24'd25811;
      4'd13:   r = 24'd22192;
      4'd14:   r = 24'd19284;
      4'd15:   r = 24'd16913;
      default: r = 24'd16913;
    endcase
    return r;
  endfunction

endpackage

// ----- hw/rtl/cts_ctrl.sv -----
module cts_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         cfg_wr_en,
  input  logic [cts_pkg::CountW-1:0]   cfg_wr_data,
  input  cts_pkg::cts_status_t         status,
  output cts_pkg::cts_cmd_t            cmd
);
  import cts_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SQ0  = 4'd1;
  localparam logic [3:0] S_SQ1  = 4'd2;
  localparam logic [3:0] S_SQW  = 4'd3;
  localparam logic [3:0] S_TA0  = 4'd4;
  localparam logic [3:0] S_TA1  = 4'd5;
  localparam logic [3:0] S_TAW  = 4'd6;
  localparam logic [3:0] S_TB0  = 4'd7;
  localparam logic [3:0] S_TB1  = 4'd8;
  localparam logic [3:0] S_TBW  = 4'd9;
  localparam logic [3:0] S_ADD  = 4'd10;
  localparam logic [3:0] S_FIN  = 4'd11;

  logic [3:0]        state;
  logic [3:0]        state_next;
  logic [CountW-1:0] k;
  logic [CountW-1:0] k_next;
  logic [CountW-1:0] term_count;
  logic [CountW-1:0] n_clip;

  assign n_clip = (term_count > CountW'(MAX_TERMS)) ? CountW'(MAX_TERMS) : term_count;
  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      term_count <= CountW'(TERM_COUNT_RESET);
    end else if (cfg_wr_en) begin
      term_count <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      k     <= '0;
    end else begin
      state <= state_next;
      k     <= k_next;
    end
  end

  always_comb begin
    state_next = state;
    k_next     = k;
    cmd        = '0;
    cmd.k      = k;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_angle = 1'b1;
          k_next         = CountW'(1);
          state_next     = S_SQ0;
        end
      end
      S_SQ0: begin
        cmd.op_sel = OP_SQ;
        cmd.mul_lo = 1'b1;
        state_next = S_SQ1;
      end
      S_SQ1: begin
        cmd.op_sel = OP_SQ;
        cmd.mul_hi = 1'b1;
        state_next = S_SQW;
      end
      S_SQW: begin
        cmd.op_sel = OP_SQ;
        cmd.wr_x2  = 1'b1;
        state_next = (n_clip == '0) ? S_FIN : S_TA0;
      end
      S_TA0: begin
        cmd.op_sel = OP_TX;
        cmd.mul_lo = 1'b1;
        state_next = S_TA1;
      end
      S_TA1: begin
        cmd.op_sel = OP_TX;
        cmd.mul_hi = 1'b1;
        state_next = S_TAW;
      end
      S_TAW: begin
        cmd.op_sel = OP_TX;
        cmd.wr_p   = 1'b1;
        state_next = S_TB0;
      end
      S_TB0: begin
        cmd.op_sel = OP_PR;
        cmd.mul_lo = 1'b1;
        state_next = S_TB1;
      end
      S_TB1: begin
        cmd.op_sel = OP_PR;
        cmd.mul_hi = 1'b1;
        state_next = S_TBW;
      end
      S_TBW: begin
        cmd.op_sel = OP_PR;
        cmd.wr_t   = 1'b1;
        state_next = S_ADD;
      end
      S_ADD: begin
        cmd.s_upd = 1'b1;
        if (k == n_clip) begin
          state_next = S_FIN;
        end else begin
          k_next     = k + CountW'(1);
          state_next = S_TA0;
        end
      end
      S_FIN: begin
        if (status.out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- hw/rtl/cts_dp.sv -----
module cts_dp (
  input  logic                               clk,
  input  logic                               rst,
  input  cts_pkg::cts_cmd_t                  cmd,
  output cts_pkg::cts_status_t               status,
  input  logic signed [cts_pkg::AngleW-1:0]  angle,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [cts_pkg::CosW-1:0]    cosine,
  output logic                               saturated
);
  import cts_pkg::*;

  logic [MagW-1:0]          mag;
  logic [MagW-1:0]          mag_in;
  logic [X2W-1:0]           x2;
  logic [ProdW-1:0]         p;
  logic [TermW-1:0]         t;
  logic signed [SumW-1:0]   s;
  logic [AccW-1:0]          acc;
  logic [PpW-1:0]           pp;
  logic [ProdW-1:0]         op_a;
  logic [X2W-1:0]           op_b;
  logic                     rnd;
  logic [HalfW-1:0]         a_half;
  logic [PpW-1:0]           pp_next;
  logic [AccW-1:0]          full;
  logic [ProdW-1:0]         mres;
  logic signed [SumW-1:0]   t_ext;
  logic signed [SumW-1:0]   s_bias;
  logic signed [RndW-1:0]   c;

  assign mag_in = angle[AngleW-1] ? (~angle + MagW'(1)) : angle;

  always_comb begin
    case (cmd.op_sel)
      OP_SQ: begin
        op_a = {{(ProdW-MagW){1'b0}}, mag};
        op_b = {{(X2W-MagW){1'b0}}, mag};
        rnd  = 1'b0;
      end
      OP_TX: begin
        op_a = {{(ProdW-TermW){1'b0}}, t};
        op_b = x2;
        rnd  = 1'b1;
      end
      OP_PR: begin
        op_a = p;
        op_b = {{(X2W-RecipW){1'b0}}, recip(cmd.k - CountW'(1))};
        rnd  = 1'b1;
      end
      default: begin
        op_a = '0;
        op_b = '0;
        rnd  = 1'b0;
      end
    endcase
  end

  assign a_half  = cmd.mul_lo ? op_a[HalfW-1:0] : op_a[ProdW-1:HalfW];
  assign pp_next = PpW'({{(PpW-HalfW){1'b0}}, a_half} * {{(PpW-X2W){1'b0}}, op_b});
  assign full    = acc + AccW'({pp, {HalfW{1'b0}}});
  assign mres    = full[FracW+ProdW-1:FracW];

  assign t_ext  = SumW'(signed'({1'b0, t}));
  assign s_bias = s + SumW'(512);
  assign c      = s_bias[SumW-1:10];

  assign status.out_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (cmd.load_angle) begin
      mag <= mag_in;
      t   <= TermW'(1) << FracW;
      s   <= SumW'(1) << FracW;
    end
    if (cmd.mul_lo || cmd.mul_hi) begin
      pp <= pp_next;
    end
    if (cmd.mul_hi) begin
      acc <= AccW'(pp) + (rnd ? (AccW'(1) << (FracW - 1)) : AccW'(0));
    end
    if (cmd.wr_x2) begin
      x2 <= full[X2W-1:0];
    end
    if (cmd.wr_p) begin
      p <= mres;
    end
    if (cmd.wr_t) begin
      t <= mres[TermW-1:0];
    end
    if (cmd.s_upd) begin
      s <= cmd.k[0] ? (s - t_ext) : (s + t_ext);
    end
    if (cmd.out_load) begin
      if (c > RndW'(524287)) begin
        cosine    <= CosW'(524287);
        saturated <= 1'b1;
      end else if (c < -RndW'(524288)) begin
        cosine    <= CosW'(-524288);
        saturated <= 1'b1;
      end else begin
        cosine    <= c[CosW-1:0];
        saturated <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ----- hw/rtl/cosine_taylor_series.sv -----
// Cosine of a signed Q3.12 angle by a truncated Taylor series with term_count terms after
// the leading one (values above twelve act as twelve), returned as signed Q5.14 with a
// saturation flag. All products go through one shared 20 by 31 bit multiplier, each product
// taking a low-half step, a high-half step and a write-back step; an item first forms the
// square of the angle, then for each term its two products and the running sum. The
// finished result sits in an output register, and the next item is accepted once that
// register has been loaded. term_count resets to six and should be written only while the
// block is idle.
module cosine_taylor_series (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [cts_pkg::AngleW-1:0]  angle,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [cts_pkg::CosW-1:0]    cosine,
  output logic                               saturated,
  input  logic                               cfg_wr_en,
  input  logic [cts_pkg::CountW-1:0]         cfg_wr_data
);
  import cts_pkg::*;

  cts_cmd_t    cmd;
  cts_status_t status;

  cts_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .status      (status),
    .cmd         (cmd)
  );

  cts_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .angle     (angle),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cosine    (cosine),
    .saturated (saturated)
  );

endmodule
